/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the IQ correction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define IQC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be true outside reset.
`define IQC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/iqc_pkg.sv */
// Types and constants shared by the IQ imbalance correction table blocks.
package iqc_pkg;

    localparam int ADDR_W     = 13;
    localparam int VALUE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SB_W       = 3;
    localparam int BIAS_W     = 17;
    localparam int FACTOR_W   = 24;
    localparam int FHALF_W    = 12;
    localparam int TRIG_W     = 18;
    localparam int FRAC_SHIFT = 10;
    localparam int DIFF_W     = 18;
    localparam int YI_W       = DIFF_W + FACTOR_W + 1;
    localparam int AB_W       = DIFF_W + TRIG_W + 1;
    localparam int PP_W       = AB_W + FHALF_W + 1;
    localparam int YQ_W       = 62;
    localparam int YI_SHIFT   = 18;
    localparam int YQ_SHIFT   = 34;
    localparam int QI_W       = YI_W - YI_SHIFT;
    localparam int QQ_W       = YQ_W - YQ_SHIFT;
    localparam int NSTG       = 6;

    localparam logic signed [QQ_W-1:0] SAT_MAX = QQ_W'(32767);
    localparam logic signed [QQ_W-1:0] SAT_MIN = -QQ_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Q      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_I    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_Q    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_COS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_PHASE   = 3'd6;

    typedef struct packed {
        logic [SB_W-1:0]            sample_bits;
        logic signed [BIAS_W-1:0]   bias_i;
        logic signed [BIAS_W-1:0]   bias_q;
        logic [FACTOR_W-1:0]        factor_i;
        logic [FACTOR_W-1:0]        factor_q;
        logic [TRIG_W-1:0]          inv_cos;
        logic signed [TRIG_W-1:0]   tan_phase;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sample_bits: 3'd5,
        bias_i:      '0,
        bias_q:      '0,
        factor_i:    24'd262144,
        factor_q:    24'd262144,
        inv_cos:     18'd65536,
        tan_phase:   '0
    };

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic            out_vld;
    } t_pipe_ctl;

endpackage

/* hw/rtl/iq_imbalance_correction_lut.sv */
// Top level of the IQ imbalance correction table.
// Each request carries one 13-bit table address and yields one corrected 16-bit word. A new
// request is taken every clock while the pipeline is not stalled, so the sustained rate is
// one result per cycle. The datapath has six register stages: decode, the three first
// multiplies, the split gain multiplies, the partial sums, the channel subtraction, and
// truncation with saturation in the output register. The input side keeps accepting while
// a result waits at the output until every stage is occupied.
module iq_imbalance_correction_lut import iqc_pkg::*; #(
    parameter int MAX_SAMPLE_BITS = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ADDR_W-1:0]         i_table_address,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_corrected_value,
    output logic                      o_entry_used,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg      cfg;
    t_pipe_ctl ctl;

    iqc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iqc_pipe_ctrl u_pipe_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    iqc_datapath #(
        .MAX_SAMPLE_BITS (MAX_SAMPLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_cfg             (cfg),
        .i_ctl             (ctl),
        .i_table_address   (i_table_address),
        .o_corrected_value (o_corrected_value),
        .o_entry_used      (o_entry_used)
    );

    assign o_out_valid = ctl.out_vld;

endmodule

/* hw/rtl/iqc_cfg_regs.sv */
// Configuration register file of the IQ correction table.
`include "assert_macros.svh"

module iqc_cfg_regs import iqc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_BITS: n_cfg.sample_bits = i_cfg_data[SB_W-1:0];
                CFG_BIAS_I:      n_cfg.bias_i      = $signed(i_cfg_data[BIAS_W-1:0]);
                CFG_BIAS_Q:      n_cfg.bias_q      = $signed(i_cfg_data[BIAS_W-1:0]);
                CFG_FACTOR_I:    n_cfg.factor_i    = i_cfg_data[FACTOR_W-1:0];
                CFG_FACTOR_Q:    n_cfg.factor_q    = i_cfg_data[FACTOR_W-1:0];
                CFG_INV_COS:     n_cfg.inv_cos     = i_cfg_data[TRIG_W-1:0];
                CFG_TAN_PHASE:   n_cfg.tan_phase   = $signed(i_cfg_data[TRIG_W-1:0]);
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    `IQC_ASSERT(a_cfg_unknown_index_ignored,
        (i_cfg_valid && o_cfg_ready && i_cfg_index > CFG_TAN_PHASE) |=> (r_cfg == $past(r_cfg)),
        "Write to an unknown register index changed the configuration.")

endmodule

/* hw/rtl/iqc_pipe_ctrl.sv */
// Valid bits and per-stage advance enables of the correction pipeline.
`include "assert_macros.svh"

module iqc_pipe_ctrl import iqc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] stg_en;
    logic            in_acc;
    logic            out_acc;

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_comb begin
        n_vld    = r_vld;
        if (stg_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready    = stg_en[0];
    assign o_ctl.en      = stg_en;
    assign o_ctl.out_vld = r_vld[NSTG-1];
    assign in_acc        = i_in_valid && o_in_ready;
    assign out_acc       = r_vld[NSTG-1] && i_out_ready;

    `IQC_ASSERT_NEVER(a_pipe_stall_only_when_full,
        !o_in_ready && !(&r_vld),
        "Input request refused while the pipeline has an empty stage.")

    `IQC_ASSERT(a_pipe_accept_enters,
        in_acc |=> r_vld[0],
        "Accepted request did not enter the first stage.")

    `IQC_ASSERT(a_pipe_count_kept,
        1'b1 |=> ($countones(r_vld) ==
            $past($countones(r_vld)) + int'($past(in_acc)) - int'($past(out_acc))),
        "Pipeline lost or duplicated a request.")

endmodule

/* hw/rtl/iqc_datapath.sv */
// Six-stage datapath: address decode, multiplies, sums, truncation and saturation.
module iqc_datapath import iqc_pkg::*; #(
    parameter int MAX_SAMPLE_BITS = 6
) (
    input  logic                      i_clk,
    input  t_cfg                      i_cfg,
    input  t_pipe_ctl                 i_ctl,
    input  logic [ADDR_W-1:0]         i_table_address,
    output logic signed [VALUE_W-1:0] o_corrected_value,
    output logic                      o_entry_used
);

    localparam int M = MAX_SAMPLE_BITS;

    logic [SB_W-1:0] n_bits;
    logic [SB_W-1:0] pad;
    logic [M-1:0]    lo_field;
    logic [M-1:0]    up_field;
    logic [M-1:0]    pmask;
    logic [M-1:0]    lower;
    logic [M-1:0]    upper;
    logic            hi_clear;
    logic            n1_used;
    logic signed [DIFF_W-1:0] n1_di;
    logic signed [DIFF_W-1:0] n1_dq;

    logic r1_used, r1_sel;
    logic signed [DIFF_W-1:0] r1_di;
    logic signed [DIFF_W-1:0] r1_dq;

    logic signed [YI_W-1:0] n2_yi;
    logic signed [AB_W-1:0] n2_a;
    logic signed [AB_W-1:0] n2_b;
    logic r2_used, r2_sel;
    logic signed [YI_W-1:0] r2_yi;
    logic signed [AB_W-1:0] r2_a;
    logic signed [AB_W-1:0] r2_b;

    logic signed [PP_W-1:0] n3_alo, n3_ahi, n3_blo, n3_bhi;
    logic r3_used, r3_sel;
    logic signed [YI_W-1:0] r3_yi;
    logic signed [PP_W-1:0] r3_alo, r3_ahi, r3_blo, r3_bhi;

    logic signed [YQ_W-1:0] n4_pa, n4_pb;
    logic r4_used, r4_sel;
    logic signed [YI_W-1:0] r4_yi;
    logic signed [YQ_W-1:0] r4_pa, r4_pb;

    logic signed [YQ_W-1:0] n5_yq;
    logic signed [QI_W-1:0] n5_qi;
    logic                   rnd_i;
    logic r5_used, r5_sel;
    logic signed [YQ_W-1:0] r5_yq;
    logic signed [QI_W-1:0] r5_qi;

    logic signed [QQ_W-1:0]    qq;
    logic signed [QQ_W-1:0]    qsel;
    logic                      rnd_q;
    logic signed [VALUE_W-1:0] n6_value;
    logic                      r6_used;
    logic signed [VALUE_W-1:0] r6_value;

    always_comb begin
        if (i_cfg.sample_bits == '0) begin
            n_bits = SB_W'(1);
        end else if (i_cfg.sample_bits > SB_W'(M)) begin
            n_bits = SB_W'(M);
        end else begin
            n_bits = i_cfg.sample_bits;
        end
        pad      = SB_W'(M) - n_bits;
        lo_field = i_table_address[M:1];
        up_field = i_table_address[2*M:M+1];
        pmask    = ~({M{1'b1}} << pad);
        lower    = lo_field >> pad;
        upper    = up_field >> pad;
        hi_clear = (i_table_address >> (2 * M + 1)) == '0;
        n1_used  = hi_clear && ((lo_field & pmask) == '0) && ((up_field & pmask) == '0);
        n1_di    = $signed({{(DIFF_W - M - FRAC_SHIFT){1'b0}}, lower, {FRAC_SHIFT{1'b0}}})
                 - $signed({{(DIFF_W - BIAS_W){i_cfg.bias_i[BIAS_W-1]}}, i_cfg.bias_i});
        n1_dq    = $signed({{(DIFF_W - M - FRAC_SHIFT){1'b0}}, upper, {FRAC_SHIFT{1'b0}}})
                 - $signed({{(DIFF_W - BIAS_W){i_cfg.bias_q[BIAS_W-1]}}, i_cfg.bias_q});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_used <= n1_used;
            r1_sel  <= i_table_address[0];
            r1_di   <= n1_di;
            r1_dq   <= n1_dq;
        end
    end

    assign n2_yi = r1_di * $signed({1'b0, i_cfg.factor_i});
    assign n2_a  = r1_dq * $signed({1'b0, i_cfg.inv_cos});
    assign n2_b  = r1_di * i_cfg.tan_phase;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_used <= r1_used;
            r2_sel  <= r1_sel;
            r2_yi   <= n2_yi;
            r2_a    <= n2_a;
            r2_b    <= n2_b;
        end
    end

    assign n3_alo = r2_a * $signed({1'b0, i_cfg.factor_q[FHALF_W-1:0]});
    assign n3_ahi = r2_a * $signed({1'b0, i_cfg.factor_q[FACTOR_W-1:FHALF_W]});
    assign n3_blo = r2_b * $signed({1'b0, i_cfg.factor_i[FHALF_W-1:0]});
    assign n3_bhi = r2_b * $signed({1'b0, i_cfg.factor_i[FACTOR_W-1:FHALF_W]});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r3_used <= r2_used;
            r3_sel  <= r2_sel;
            r3_yi   <= r2_yi;
            r3_alo  <= n3_alo;
            r3_ahi  <= n3_ahi;
            r3_blo  <= n3_blo;
            r3_bhi  <= n3_bhi;
        end
    end

    assign n4_pa = (YQ_W'(r3_ahi) <<< FHALF_W) + YQ_W'(r3_alo);
    assign n4_pb = (YQ_W'(r3_bhi) <<< FHALF_W) + YQ_W'(r3_blo);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r4_used <= r3_used;
            r4_sel  <= r3_sel;
            r4_yi   <= r3_yi;
            r4_pa   <= n4_pa;
            r4_pb   <= n4_pb;
        end
    end

    // Shifts floor the value; negative values with lost fraction bits step up by one.
    assign rnd_i = r4_yi[YI_W-1] && (r4_yi[YI_SHIFT-1:0] != '0);
    assign n5_qi = QI_W'(r4_yi >>> YI_SHIFT) + $signed({{(QI_W - 1){1'b0}}, rnd_i});
    assign n5_yq = r4_pa - r4_pb;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r5_used <= r4_used;
            r5_sel  <= r4_sel;
            r5_qi   <= n5_qi;
            r5_yq   <= n5_yq;
        end
    end

    always_comb begin
        rnd_q = r5_yq[YQ_W-1] && (r5_yq[YQ_SHIFT-1:0] != '0);
        qq    = QQ_W'(r5_yq >>> YQ_SHIFT) + $signed({{(QQ_W - 1){1'b0}}, rnd_q});
        qsel  = r5_sel ? qq : QQ_W'(r5_qi);
        if (!r5_used) begin
            n6_value = '0;
        end else if (qsel > SAT_MAX) begin
            n6_value = SAT_MAX[VALUE_W-1:0];
        end else if (qsel < SAT_MIN) begin
            n6_value = SAT_MIN[VALUE_W-1:0];
        end else begin
            n6_value = qsel[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r6_used  <= r5_used;
            r6_value <= n6_value;
        end
    end

    assign o_corrected_value = r6_value;
    assign o_entry_used      = r6_used;

endmodule

/* dv/iqc_correction_checker.sv */
`timescale 1ns / 1ps
// Checker for the IQ imbalance correction table: predicts each corrected word and compares.
module iqc_correction_checker import iqc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [ADDR_W-1:0]         i_table_address,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [VALUE_W-1:0] i_corrected_value,
    input  logic                      i_entry_used,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                        o_n_waiting,
    output int                        o_mismatches
);

    localparam int MAX_SB = 6;
    localparam int PRINT_CAP = 200;
    localparam longint YI_DIV = longint'(1) << YI_SHIFT;
    localparam longint YQ_DIV = longint'(1) << YQ_SHIFT;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      used;
    } t_word;

    t_cfg  regs;
    t_word expected_words[$];
    t_word head_word;
    int    mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic t_word correct_entry(input t_cfg c, input logic [ADDR_W-1:0] addr);
        int               n;
        int               pad;
        logic [ADDR_W-1:0] fmask;
        logic [ADDR_W-1:0] pmask;
        longint           lower;
        longint           upper;
        longint           di;
        longint           dq;
        longint           yi;
        longint           yq;
        longint           r;
        t_word            w;
        n = int'(c.sample_bits);
        if (n < 1) n = 1;
        if (n > MAX_SB) n = MAX_SB;
        pad = MAX_SB - n;
        fmask = ADDR_W'((1 << n) - 1);
        pmask = ADDR_W'((1 << pad) - 1);
        w.value = '0;
        w.used = 1'b0;
        if ((((addr >> 1) & pmask) != 0) || (((addr >> (MAX_SB + 1)) & pmask) != 0)
                || ((addr >> (2 * MAX_SB + 1)) != 0)) begin
            return w;
        end
        lower = longint'((addr >> (1 + pad)) & fmask);
        upper = longint'((addr >> (MAX_SB + 1 + pad)) & fmask);
        di = lower * 1024 - longint'($signed(c.bias_i));
        yi = di * longint'({1'b0, c.factor_i});
        if (!addr[0]) begin
            r = yi / YI_DIV;
        end else begin
            dq = upper * 1024 - longint'($signed(c.bias_q));
            yq = dq * longint'({1'b0, c.factor_q}) * longint'({1'b0, c.inv_cos})
                - yi * longint'($signed(c.tan_phase));
            r = yq / YQ_DIV;
        end
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        w.value = r[VALUE_W-1:0];
        w.used = 1'b1;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = CFG_RESET;
            expected_words.delete();
            o_n_waiting <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SAMPLE_BITS: regs.sample_bits = i_cfg_data[SB_W-1:0];
                    CFG_BIAS_I:      regs.bias_i      = i_cfg_data[BIAS_W-1:0];
                    CFG_BIAS_Q:      regs.bias_q      = i_cfg_data[BIAS_W-1:0];
                    CFG_FACTOR_I:    regs.factor_i    = i_cfg_data[FACTOR_W-1:0];
                    CFG_FACTOR_Q:    regs.factor_q    = i_cfg_data[FACTOR_W-1:0];
                    CFG_INV_COS:     regs.inv_cos     = i_cfg_data[TRIG_W-1:0];
                    CFG_TAN_PHASE:   regs.tan_phase   = i_cfg_data[TRIG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_words.push_back(correct_entry(regs, i_table_address));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result with no request waiting",
                        int'(i_corrected_value), 0);
                end else begin
                    head_word = expected_words.pop_front();
                    if (i_corrected_value !== head_word.value) begin
                        report_mismatch("corrected_value", int'(i_corrected_value),
                            int'(head_word.value));
                    end
                    if (i_entry_used !== head_word.used) begin
                        report_mismatch("entry_used", int'(i_entry_used),
                            int'(head_word.used));
                    end
                end
            end
            o_n_waiting <= expected_words.size();
        end
    end

endmodule

/* dv/tb_iq_imbalance_correction_lut.sv */
`timescale 1ns / 1ps
// Testbench top for the IQ imbalance correction table: stimulus, back-pressure and verdict.
module tb_iq_imbalance_correction_lut import iqc_pkg::*; ();

    localparam int MAX_SB = 6;
    localparam int LATENCY = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD = 120;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 160;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [ADDR_W-1:0]         i_table_address;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [VALUE_W-1:0] o_corrected_value;
    logic                      o_entry_used;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int n_waiting;
    int mismatches;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    iq_imbalance_correction_lut #(.MAX_SAMPLE_BITS(MAX_SB)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_table_address   (i_table_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_corrected_value (o_corrected_value),
        .o_entry_used      (o_entry_used),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    iqc_correction_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_table_address   (i_table_address),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_corrected_value (o_corrected_value),
        .i_entry_used      (o_entry_used),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_n_waiting       (n_waiting),
        .o_mismatches      (mismatches)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_iq_imbalance_correction_lut NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] make_addr(input int n, input int upper,
            input int lower, input bit sel);
        int pad;
        pad = MAX_SB - n;
        return ADDR_W'((upper << (MAX_SB + 1 + pad)) | (lower << (1 + pad)) | int'(sel));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] cfg_word(input logic [CFG_DATA_W-1:0] value,
            input int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = (CFG_DATA_W'(1) << width) - 1'b1;
        return (value & mask) | (CFG_DATA_W'($urandom) & ~mask);
    endfunction

    function automatic int pick(input int lo, input int hi, input int tlo, input int thi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            2, 3: return lo + int'($urandom_range(0, hi - lo));
            default: return tlo + int'($urandom_range(0, thi - tlo));
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.sample_bits = SB_W'($urandom_range(0, 7));
        c.bias_i      = BIAS_W'(pick(-65536, 65535, -2048, 2048));
        c.bias_q      = BIAS_W'(pick(-65536, 65535, -2048, 2048));
        c.factor_i    = FACTOR_W'(pick(0, 16777215, 0, 65536));
        c.factor_q    = FACTOR_W'(pick(0, 16777215, 0, 65536));
        c.inv_cos     = TRIG_W'(pick(0, 262143, 49152, 98304));
        c.tan_phase   = TRIG_W'(pick(-131072, 131071, -16384, 16384));
        return c;
    endfunction

    task automatic send_entry(input logic [ADDR_W-1:0] addr);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_table_address <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_waiting != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        wait_idle();
        write_reg(CFG_SAMPLE_BITS, cfg_word(c.sample_bits, SB_W));
        write_reg(CFG_BIAS_I, cfg_word(c.bias_i, BIAS_W));
        write_reg(CFG_BIAS_Q, cfg_word(c.bias_q, BIAS_W));
        write_reg(CFG_FACTOR_I, cfg_word(c.factor_i, FACTOR_W));
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_FACTOR_Q, cfg_word(c.factor_q, FACTOR_W));
        write_reg(CFG_INV_COS, cfg_word(c.inv_cos, TRIG_W));
        write_reg(CFG_TAN_PHASE, cfg_word(c.tan_phase, TRIG_W));
        i_cfg_valid <= 1'b0;
    endtask

    // The receiver stalls in random bursts, and once for a long stretch so the pipe fills.
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm && hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_cfg              cur;
        int                n;
        logic [ADDR_W-1:0] addr;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_table_address <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners of both fields, both channels, and padding bits set.
        send_entry(make_addr(5, 0, 0, 1'b0));
        send_entry(make_addr(5, 0, 0, 1'b1));
        send_entry(make_addr(5, 31, 31, 1'b0));
        send_entry(make_addr(5, 31, 31, 1'b1));
        send_entry(13'h0002);
        send_entry(13'h0080);
        send_entry(13'h1FFF);

        // Widest samples with every register at an extreme, so both channels saturate.
        cur = CFG_RESET;
        cur.sample_bits = 3'd6;
        cur.bias_i = BIAS_W'(-65536);
        cur.bias_q = BIAS_W'(65535);
        cur.factor_i = 24'hFFFFFF;
        cur.factor_q = 24'hFFFFFF;
        cur.inv_cos = 18'h3FFFF;
        cur.tan_phase = TRIG_W'(-131072);
        program_regs(cur);
        send_entry(make_addr(6, 63, 63, 1'b0));
        send_entry(make_addr(6, 63, 63, 1'b1));
        send_entry(make_addr(6, 0, 0, 1'b0));
        send_entry(make_addr(6, 0, 0, 1'b1));

        // One-bit samples with the opposite extremes and zero gains.
        cur.sample_bits = 3'd1;
        cur.bias_i = BIAS_W'(65535);
        cur.bias_q = BIAS_W'(-65536);
        cur.factor_i = '0;
        cur.factor_q = '0;
        cur.inv_cos = '0;
        cur.tan_phase = TRIG_W'(131071);
        program_regs(cur);
        send_entry(make_addr(1, 1, 1, 1'b0));
        send_entry(make_addr(1, 1, 1, 1'b1));
        send_entry(make_addr(1, 0, 1, 1'b1));
        send_entry(13'h0002);
        send_entry(13'h1F9E);

        // A width of zero acts as one bit, and seven acts as the maximum width.
        cur = CFG_RESET;
        cur.sample_bits = 3'd0;
        program_regs(cur);
        send_entry(make_addr(1, 1, 1, 1'b1));
        send_entry(make_addr(1, 1, 0, 1'b0));
        send_entry(13'h0004);
        cur.sample_bits = 3'd7;
        program_regs(cur);
        send_entry(13'h1FFF);
        send_entry(13'h0AAA);

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) calm = 1'b1;
            cur = random_cfg();
            program_regs(cur);
            if (p == 1) hold_req = 1'b1;
            n = int'(cur.sample_bits);
            if (n < 1) n = 1;
            if (n > MAX_SB) n = MAX_SB;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) < 7) begin
                    addr = make_addr(n, int'($urandom_range(0, (1 << n) - 1)),
                        int'($urandom_range(0, (1 << n) - 1)), 1'($urandom));
                end else begin
                    addr = ADDR_W'($urandom);
                end
                send_entry(addr);
            end
        end

        wait_idle();
        repeat (LATENCY * 3) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_iq_imbalance_correction_lut OK");
        end else begin
            $display("tb_iq_imbalance_correction_lut NOT OK");
        end
        $finish;
    end

endmodule
